// File: rtl/dhcprr_pkg.sv
// Shared types, constants and the reply word builder for the DHCP reply responder.
// No dependencies; every other file of the block imports this package.
package dhcprr_pkg;

    // Packet and reply geometry
    localparam int MAX_PACKET_BYTES_DEF = 2048;
    localparam int REPLY_BYTES          = 300;
    localparam int REPLY_WORDS          = (REPLY_BYTES + 7) / 8;
    localparam int WORD_CNT_W           = $clog2(REPLY_WORDS);
    localparam int LAST_WORD_BYTES      = REPLY_BYTES - 8 * (REPLY_WORDS - 1);
    localparam int MIN_REQUEST_BYTES    = 240;
    localparam int OPTIONS_START        = 240;

    // Request fields
    localparam logic [7:0]  BOOTREQUEST    = 8'd1;
    localparam logic [15:0] MSG_TYPE_PAIR  = 16'h3501;
    localparam logic [7:0]  MSG_DISCOVER   = 8'd1;

    // Reply bytes
    localparam logic [7:0] BOOTREPLY      = 8'd2;
    localparam logic [7:0] HTYPE_ETHER    = 8'd1;
    localparam logic [7:0] HLEN_ETHER     = 8'd6;
    localparam logic [7:0] MAGIC_0        = 8'd99;
    localparam logic [7:0] MAGIC_1        = 8'd130;
    localparam logic [7:0] MAGIC_2        = 8'd83;
    localparam logic [7:0] MAGIC_3        = 8'd99;
    localparam logic [7:0] OPT_MSG_TYPE   = 8'h35;
    localparam logic [7:0] OPT_SUBNET     = 8'd1;
    localparam logic [7:0] OPT_ROUTER     = 8'd3;
    localparam logic [7:0] OPT_SERVER_ID  = 8'd54;
    localparam logic [7:0] OPT_LEASE      = 8'd51;
    localparam logic [7:0] OPT_END        = 8'hFF;
    localparam logic [7:0] OPT_LEN_1      = 8'd1;
    localparam logic [7:0] OPT_LEN_4      = 8'd4;
    localparam logic [7:0] MSG_OFFER      = 8'd2;
    localparam logic [7:0] MSG_ACK        = 8'd5;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFERED_ADDR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBNET_MASK  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_SECS   = 3'd3;

    localparam logic [31:0] OFFERED_ADDR_RST = 32'd3232236564;
    localparam logic [31:0] SUBNET_MASK_RST  = 32'd4294967040;
    localparam logic [31:0] ROUTER_ADDR_RST  = 32'd3232236545;
    localparam logic [31:0] LEASE_SECS_RST   = 32'd6528;

    // Reply request handed from the parser to the word generator
    typedef struct packed {
        logic        start;
        logic [31:0] xid;
        logic [47:0] chaddr;
        logic        offer;
    } reply_req_t;

    typedef struct packed {
        logic [31:0] offered_addr;
        logic [31:0] subnet_mask;
        logic [31:0] router_addr;
        logic [31:0] lease_secs;
    } reply_cfg_t;

    // One big-endian 64-bit word of the reply; all words not listed are zero
    function automatic logic [63:0] reply_word(
        input logic [WORD_CNT_W-1:0] idx,
        input reply_req_t            req,
        input reply_cfg_t            cfg
    );
        logic [7:0]  mtype;
        logic [63:0] w;
        mtype = req.offer ? MSG_OFFER : MSG_ACK;
        case (idx)
            // bytes 0..7: op, htype, hlen, hops, xid
            6'd0:  w = {BOOTREPLY, HTYPE_ETHER, HLEN_ETHER, 8'd0, req.xid};
            // bytes 16..23: yiaddr, siaddr
            6'd2:  w = {cfg.offered_addr, 32'd0};
            // bytes 24..31: giaddr, chaddr high
            6'd3:  w = {32'd0, req.chaddr[47:16]};
            // bytes 32..39: chaddr low
            6'd4:  w = {req.chaddr[15:0], 48'd0};
            // bytes 232..239: magic cookie in the lower half
            6'd29: w = {32'd0, MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
            // bytes 240..247
            6'd30: w = {OPT_MSG_TYPE, OPT_LEN_1, mtype, OPT_SUBNET, OPT_LEN_4,
                        cfg.subnet_mask[31:8]};
            // bytes 248..255
            6'd31: w = {cfg.subnet_mask[7:0], OPT_ROUTER, OPT_LEN_4,
                        cfg.router_addr, OPT_SERVER_ID};
            // bytes 256..263
            6'd32: w = {OPT_LEN_4, cfg.router_addr, OPT_LEASE, OPT_LEN_4,
                        cfg.lease_secs[31:24]};
            // bytes 264..271
            6'd33: w = {cfg.lease_secs[23:0], OPT_END, 32'd0};
            default: w = 64'd0;
        endcase
        return w;
    endfunction

endpackage

// File: rtl/dhcp_reply_responder_top.sv
// DHCP reply responder top level: configuration registers, request parser and
// reply word generator. Depends on dhcprr_pkg, dhcprr_parser and dhcprr_reply_gen.
//
// Usage:
//   Input channel (s_): one request payload byte per beat, s_end_of_packet high
//   on the final byte. A byte is taken in every cycle while s_ready is high.
//   Result channel (m_): a 300-byte reply as 38 big-endian 64-bit words,
//   m_valid_bytes is 8 except 4 on the word with m_last_word high.
//   A reply follows only a request of at least 240 bytes whose first byte is 1;
//   a DISCOVER (or no message type) gets an OFFER, anything else an ACK.
//   Reply timing: accepting the final request byte loads the sequencer, which then
//   registers the first reply word on m_; words follow one per cycle while m_ready
//   is high. Throughput: one request byte per cycle. The word sequencer holds one
//   reply at a time, so a final byte that arrives while a reply is still being
//   streamed waits (s_ready low for that beat only) until the sequencer frees.
//   Other bytes of the next request keep flowing while a reply streams.
//   Stall: when m_ready is low the output register holds its word and the
//   sequencer pauses; the parser keeps taking bytes.
//   Reset: aresetn (synchronous, active low) clears packet state, drops any reply
//   in flight and loads default addresses and lease.
//   Configuration: cfg_wr_en writes cfg_data to register cfg_index (0 offered
//   address, 1 subnet mask, 2 server address, 3 lease seconds); others ignored.
module dhcp_reply_responder_top #(
    parameter int MAX_PACKET_BYTES = dhcprr_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [dhcprr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_data_byte,
    input  logic                               s_end_of_packet,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [63:0]                        m_reply_word,
    output logic [3:0]                         m_valid_bytes,
    output logic                               m_last_word
);
    import dhcprr_pkg::*;

    reply_cfg_t cfg_reg;
    reply_req_t req;
    logic       gen_busy;
    logic       byte_accept;

    // Configuration registers; write them only while no reply is in flight
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.offered_addr <= OFFERED_ADDR_RST;
            cfg_reg.subnet_mask  <= SUBNET_MASK_RST;
            cfg_reg.router_addr  <= ROUTER_ADDR_RST;
            cfg_reg.lease_secs   <= LEASE_SECS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_OFFERED_ADDR: cfg_reg.offered_addr <= cfg_data;
                CFG_SUBNET_MASK:  cfg_reg.subnet_mask  <= cfg_data;
                CFG_ROUTER_ADDR:  cfg_reg.router_addr  <= cfg_data;
                CFG_LEASE_SECS:   cfg_reg.lease_secs   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Hold back only a final byte while the sequencer still owns a reply
    assign s_ready     = !(gen_busy && s_end_of_packet);
    assign byte_accept = s_valid && s_ready;

    dhcprr_parser #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .byte_accept   (byte_accept),
        .data_byte     (s_data_byte),
        .end_of_packet (s_end_of_packet),
        .req           (req)
    );

    dhcprr_reply_gen u_reply_gen (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .req           (req),
        .cfg           (cfg_reg),
        .busy          (gen_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_reply_word  (m_reply_word),
        .m_valid_bytes (m_valid_bytes),
        .m_last_word   (m_last_word)
    );

endmodule

// File: rtl/dhcprr_parser.sv
// Request byte parser: tracks position and captures xid, chaddr and message type.
// Depends on dhcprr_pkg; raises a reply request on the last byte of a valid request.
module dhcprr_parser #(
    parameter int MAX_PACKET_BYTES = dhcprr_pkg::MAX_PACKET_BYTES_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    byte_accept,
    input  logic [7:0]              data_byte,
    input  logic                    end_of_packet,
    output dhcprr_pkg::reply_req_t  req
);
    import dhcprr_pkg::*;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_PACKET_BYTES - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       first_reg, first_next;
    logic [31:0]      xid_reg, xid_next;
    logic [47:0]      chaddr_reg, chaddr_next;
    logic             found_reg, found_next;
    logic [7:0]       mtype_reg, mtype_next;
    logic [15:0]      prev_reg, prev_next;
    logic             len_ok;

    always_comb begin
        first_next  = (pos_reg == '0) ? data_byte : first_reg;
        xid_next    = xid_reg;
        chaddr_next = chaddr_reg;
        found_next  = found_reg;
        mtype_next  = mtype_reg;
        if (pos_reg >= POS_W'(4) && pos_reg <= POS_W'(7)) begin
            xid_next = {xid_reg[23:0], data_byte};
        end
        if (pos_reg >= POS_W'(28) && pos_reg <= POS_W'(33)) begin
            chaddr_next = {chaddr_reg[39:0], data_byte};
        end
        if (!found_reg && pos_reg >= POS_W'(OPTIONS_START + 2) &&
            prev_reg == MSG_TYPE_PAIR) begin
            mtype_next = data_byte;
            found_next = 1'b1;
        end
        prev_next = {prev_reg[7:0], data_byte};
        pos_next  = (pos_reg < POS_TOP) ? pos_reg + POS_W'(1) : pos_reg;
    end

    // Length is pos + 1, so at least the minimum once pos reaches minimum - 1
    assign len_ok = pos_reg >= POS_W'(MIN_REQUEST_BYTES - 1);

    always_comb begin
        req.start  = byte_accept && end_of_packet && len_ok && (first_next == BOOTREQUEST);
        req.xid    = xid_next;
        req.chaddr = chaddr_next;
        req.offer  = (mtype_next == MSG_DISCOVER);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            first_reg  <= '0;
            xid_reg    <= '0;
            chaddr_reg <= '0;
            found_reg  <= 1'b0;
            mtype_reg  <= MSG_DISCOVER;
            prev_reg   <= '0;
        end else if (byte_accept) begin
            if (end_of_packet) begin
                // Clear all packet state, reply or not
                pos_reg    <= '0;
                first_reg  <= '0;
                xid_reg    <= '0;
                chaddr_reg <= '0;
                found_reg  <= 1'b0;
                mtype_reg  <= MSG_DISCOVER;
                prev_reg   <= '0;
            end else begin
                pos_reg    <= pos_next;
                first_reg  <= first_next;
                xid_reg    <= xid_next;
                chaddr_reg <= chaddr_next;
                found_reg  <= found_next;
                mtype_reg  <= mtype_next;
                prev_reg   <= prev_next;
            end
        end
    end

endmodule

// File: rtl/dhcprr_reply_gen.sv
// Reply word sequencer: holds one reply request and streams its words through an
// output register. Depends on dhcprr_pkg for the request type and word builder.
module dhcprr_reply_gen (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  dhcprr_pkg::reply_req_t  req,
    input  dhcprr_pkg::reply_cfg_t  cfg,
    output logic                    busy,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [63:0]             m_reply_word,
    output logic [3:0]              m_valid_bytes,
    output logic                    m_last_word
);
    import dhcprr_pkg::*;

    localparam logic [WORD_CNT_W-1:0] LAST_IDX = WORD_CNT_W'(REPLY_WORDS - 1);

    logic                  active_reg;
    logic [WORD_CNT_W-1:0] cnt_reg;
    reply_req_t            hold_reg;
    logic                  m_valid_reg;
    logic [63:0]           word_reg;
    logic [3:0]            nbytes_reg;
    logic                  last_reg;
    logic                  load;
    logic                  cnt_last;

    assign cnt_last = (cnt_reg == LAST_IDX);
    assign load     = active_reg && (!m_valid_reg || m_ready);
    assign busy     = active_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (req.start && !active_reg) begin
                active_reg <= 1'b1;
                cnt_reg    <= '0;
            end else if (load) begin
                cnt_reg <= cnt_last ? '0 : cnt_reg + WORD_CNT_W'(1);
                if (cnt_last) begin
                    active_reg <= 1'b0;
                end
            end
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start && !active_reg) begin
            hold_reg <= req;
        end
        if (load) begin
            word_reg   <= reply_word(cnt_reg, hold_reg, cfg);
            nbytes_reg <= cnt_last ? 4'(LAST_WORD_BYTES) : 4'd8;
            last_reg   <= cnt_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_reply_word  = word_reg;
    assign m_valid_bytes = nbytes_reg;
    assign m_last_word   = last_reg;

    a_no_start_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        !(req.start && active_reg))
        else $error("reply request arrived while a reply was streaming");

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= LAST_IDX)
        else $error("word counter out of range");

    a_idle_cnt_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> cnt_reg == '0)
        else $error("word counter not parked while idle");

    a_end_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(active_reg) |-> m_valid_reg && last_reg)
        else $error("reply ended without a last word");

endmodule

// File: tb/sv/dhcp_reply_responder_top_test.sv
// Self-checking testbench for dhcp_reply_responder_top: streams request bytes and checks
// every 64-bit reply beat against a built-in predictor. Depends on dhcprr_pkg and the RTL.
module dhcp_reply_responder_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dhcprr_pkg::*;

    // Saturation point of the byte position, and a no-progress limit for the watchdog
    localparam int PKT_MAX     = MAX_PACKET_BYTES_DEF;
    localparam int STALL_LIMIT = 4000;

    // DHCP REQUEST code: anything that is not a DISCOVER must draw an acknowledge
    localparam logic [7:0] MSG_REQUEST = 8'd3;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  nbytes;
        logic        last;
    } reply_beat_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [7:0]           s_data_byte;
    logic                 s_end_of_packet;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [63:0]          m_reply_word;
    logic [3:0]           m_valid_bytes;
    logic                 m_last_word;

    // Idle percentages for the sender and the receiver; changed per phase
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Predicted reply beats, oldest first
    reply_beat_t reply_words_due[$];

    // Request bytes of the packet being assembled by a test
    logic [7:0] pkt_bytes[$];

    // Predictor copy of the registers
    logic [31:0] cfg_offered;
    logic [31:0] cfg_mask;
    logic [31:0] cfg_server;
    logic [31:0] cfg_lease;

    // Predictor copy of the per-packet parse state
    int          req_pos;
    logic [7:0]  req_lead;
    logic [31:0] req_xid;
    logic [47:0] req_chaddr;
    logic        req_type_seen;
    logic [7:0]  req_type;
    logic [15:0] req_prev2;

    dhcp_reply_responder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data_byte     (s_data_byte),
        .s_end_of_packet (s_end_of_packet),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reply_word    (m_reply_word),
        .m_valid_bytes   (m_valid_bytes),
        .m_last_word     (m_last_word)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Receiver: stall at random on the falling edge, at the rate of the current phase
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted reply beat with the oldest prediction, field by field
    always @(posedge aclk) begin
        reply_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reply_words_due.size() == 0) begin
                $display("%0t: unexpected reply beat word=%h bytes=%0d last=%b",
                         $time, m_reply_word, m_valid_bytes, m_last_word);
                mismatch_count++;
            end else begin
                want = reply_words_due.pop_front();
                if (m_reply_word !== want.word) begin
                    $display("%0t: reply_word expected %h actual %h",
                             $time, want.word, m_reply_word);
                    mismatch_count++;
                end
                if (m_valid_bytes !== want.nbytes) begin
                    $display("%0t: valid_bytes expected %0d actual %0d",
                             $time, want.nbytes, m_valid_bytes);
                    mismatch_count++;
                end
                if (m_last_word !== want.last) begin
                    $display("%0t: last_word expected %b actual %b",
                             $time, want.last, m_last_word);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run once nothing moves on either channel for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("dhcp_reply_responder_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drop all per-packet parse state back to its reset value
    function automatic void clear_request();
        req_pos       = 0;
        req_lead      = 8'h00;
        req_xid       = 32'h0;
        req_chaddr    = 48'h0;
        req_type_seen = 1'b0;
        req_type      = MSG_DISCOVER;
        req_prev2     = 16'h0;
    endfunction

    // Advance the parse state by one request byte; on an accepted final byte of a
    // well-formed request, queue the 38 reply beats it must produce.
    task automatic absorb_request_byte(input logic [7:0] b, input logic eop);
        logic [7:0]  rb [0:REPLY_WORDS*8-1];
        logic [63:0] w;
        reply_beat_t beat;
        int          k;
        int          j;
        if (req_pos == 0)
            req_lead = b;
        if (req_pos >= 4 && req_pos <= 7)
            req_xid = {req_xid[23:0], b};
        if (req_pos >= 28 && req_pos <= 33)
            req_chaddr = {req_chaddr[39:0], b};
        // Only the first type option counts, and only once the pair sits at or past 240
        if (!req_type_seen && req_pos >= OPTIONS_START + 2 && req_prev2 == MSG_TYPE_PAIR) begin
            req_type      = b;
            req_type_seen = 1'b1;
        end
        req_prev2 = {req_prev2[7:0], b};

        if (!eop) begin
            if (req_pos < PKT_MAX - 1)
                req_pos++;
            return;
        end

        if (req_pos + 1 >= MIN_REQUEST_BYTES && req_lead == BOOTREQUEST) begin
            for (k = 0; k < REPLY_WORDS * 8; k++)
                rb[k] = 8'h00;
            rb[0]   = BOOTREPLY;
            rb[1]   = HTYPE_ETHER;
            rb[2]   = HLEN_ETHER;
            rb[236] = MAGIC_0;
            rb[237] = MAGIC_1;
            rb[238] = MAGIC_2;
            rb[239] = MAGIC_3;
            rb[240] = OPT_MSG_TYPE;
            rb[241] = OPT_LEN_1;
            rb[242] = (req_type == MSG_DISCOVER) ? MSG_OFFER : MSG_ACK;
            rb[243] = OPT_SUBNET;
            rb[244] = OPT_LEN_4;
            rb[249] = OPT_ROUTER;
            rb[250] = OPT_LEN_4;
            rb[255] = OPT_SERVER_ID;
            rb[256] = OPT_LEN_4;
            rb[261] = OPT_LEASE;
            rb[262] = OPT_LEN_4;
            rb[267] = OPT_END;
            for (j = 0; j < 4; j++) begin
                rb[4 + j]   = req_xid[31 - 8*j -: 8];
                rb[16 + j]  = cfg_offered[31 - 8*j -: 8];
                rb[245 + j] = cfg_mask[31 - 8*j -: 8];
                rb[251 + j] = cfg_server[31 - 8*j -: 8];
                rb[257 + j] = cfg_server[31 - 8*j -: 8];
                rb[263 + j] = cfg_lease[31 - 8*j -: 8];
            end
            for (j = 0; j < 6; j++)
                rb[28 + j] = req_chaddr[47 - 8*j -: 8];
            // Pack big-endian: the first byte of each group lands in bits 63..56
            for (k = 0; k < REPLY_WORDS; k++) begin
                w = 64'h0;
                for (j = 0; j < 8; j++)
                    w = {w[55:0], rb[k*8 + j]};
                beat.word   = w;
                beat.nbytes = (k == REPLY_WORDS - 1) ? 4'(LAST_WORD_BYTES) : 4'd8;
                beat.last   = (k == REPLY_WORDS - 1);
                reply_words_due.push_back(beat);
            end
        end
        clear_request();
    endtask

    // Send one request byte: idle at random first, hold the beat until it is taken,
    // then predict. Entered and left on a falling edge.
    task automatic send_byte(input logic [7:0] b, input logic eop);
        while ($urandom_range(99) < gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid         = 1'b1;
        s_data_byte     = b;
        s_end_of_packet = eop;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        absorb_request_byte(b, eop);
        @(negedge aclk);
        s_valid         = 1'b0;
        s_end_of_packet = 1'b0;
    endtask

    // Fill pkt_bytes with random content, a chosen first byte and, if pair_at is not
    // negative, the message-type pair and type byte from that offset (clipped at the end)
    function automatic void build_request(input int len, input logic [7:0] lead,
                                          input int pair_at, input logic [7:0] mtype);
        int i;
        pkt_bytes.delete();
        for (i = 0; i < len; i++)
            pkt_bytes.push_back(8'($urandom));
        if (len > 0)
            pkt_bytes[0] = lead;
        if (pair_at >= 0) begin
            if (pair_at < len)
                pkt_bytes[pair_at] = OPT_MSG_TYPE;
            if (pair_at + 1 < len)
                pkt_bytes[pair_at + 1] = OPT_LEN_1;
            if (pair_at + 2 < len)
                pkt_bytes[pair_at + 2] = mtype;
        end
    endfunction

    task automatic send_packet();
        int i;
        int n;
        n = pkt_bytes.size();
        for (i = 0; i < n; i++)
            send_byte(pkt_bytes[i], i == n - 1);
    endtask

    // Hold the sender until every predicted beat has come out
    task automatic wait_replies_drained();
        while (reply_words_due.size() != 0)
            @(negedge aclk);
    endtask

    // Drain, then let the pipeline settle past its latency before touching registers
    task automatic quiesce();
        wait_replies_drained();
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_OFFERED_ADDR: cfg_offered = val;
            CFG_SUBNET_MASK:  cfg_mask    = val;
            CFG_ROUTER_ADDR:  cfg_server  = val;
            CFG_LEASE_SECS:   cfg_lease   = val;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] offered, input logic [31:0] mask,
                                  input logic [31:0] server, input logic [31:0] lease);
        quiesce();
        write_reg(CFG_OFFERED_ADDR, offered);
        write_reg(CFG_SUBNET_MASK, mask);
        write_reg(CFG_ROUTER_ADDR, server);
        write_reg(CFG_LEASE_SECS, lease);
    endtask

    // Minimal legal request with reset registers: exactly 240 bytes, no type option
    task automatic test_reset_defaults();
        build_request(MIN_REQUEST_BYTES, BOOTREQUEST, -1, 8'h00);
        send_packet();
    endtask

    // Message-type scan: offer vs acknowledge, first match only, window edges
    task automatic test_message_type_scan();
        build_request(300, BOOTREQUEST, OPTIONS_START, MSG_DISCOVER);
        send_packet();
        build_request(300, BOOTREQUEST, OPTIONS_START, MSG_REQUEST);
        send_packet();
        build_request(260, BOOTREQUEST, OPTIONS_START, 8'h00);
        send_packet();
        // pair further into the options, extreme type value
        build_request(280, BOOTREQUEST, 250, 8'hFF);
        send_packet();
        // two pairs: the later DISCOVER must not override the earlier type
        build_request(300, BOOTREQUEST, OPTIONS_START, MSG_ACK);
        pkt_bytes[260] = OPT_MSG_TYPE;
        pkt_bytes[261] = OPT_LEN_1;
        pkt_bytes[262] = MSG_DISCOVER;
        send_packet();
        // pair starting one byte before the options: not counted, so an offer
        build_request(280, BOOTREQUEST, OPTIONS_START - 1, MSG_REQUEST);
        send_packet();
        // type byte would fall past the end: default type
        build_request(260, BOOTREQUEST, 258, MSG_REQUEST);
        send_packet();
        // type byte is the final byte: counted
        build_request(260, BOOTREQUEST, 257, MSG_REQUEST);
        send_packet();
    endtask

    // Requests that draw no reply, followed by a good one to prove the state cleared
    task automatic test_rejected_requests();
        build_request(MIN_REQUEST_BYTES - 1, BOOTREQUEST, -1, 8'h00);
        send_packet();
        build_request(1, BOOTREQUEST, -1, 8'h00);
        send_packet();
        build_request(300, 8'h00, OPTIONS_START, MSG_REQUEST);
        send_packet();
        build_request(300, BOOTREPLY, OPTIONS_START, MSG_REQUEST);
        send_packet();
        build_request(250, 8'hFF, -1, 8'h00);
        send_packet();
        build_request(MIN_REQUEST_BYTES, BOOTREQUEST, -1, 8'h00);
        send_packet();
    endtask

    // Register extremes, plus writes to indexes past the last register
    task automatic test_register_extremes();
        write_all_regs(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        build_request(260, BOOTREQUEST, OPTIONS_START, MSG_REQUEST);
        send_packet();
        write_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        build_request(260, BOOTREQUEST, OPTIONS_START, MSG_DISCOVER);
        send_packet();
        quiesce();
        write_reg(CFG_LEASE_SECS + 3'd1, 32'h1234_5678);
        write_reg(CFG_LEASE_SECS + 3'd4, 32'h0000_0000);
        build_request(260, BOOTREQUEST, -1, 8'h00);
        send_packet();
    endtask

    // Position saturation: exactly the maximum, and well past it with a late type pair
    task automatic test_saturated_length();
        build_request(PKT_MAX, BOOTREQUEST, -1, 8'h00);
        send_packet();
        build_request(PKT_MAX + 52, BOOTREQUEST, PKT_MAX + 12, MSG_REQUEST);
        send_packet();
    endtask

    // Random traffic in four idle phases; mostly well-formed requests with random
    // content, the rest wrong first bytes, short packets and a rare oversized one
    task automatic test_random_traffic();
        int          phase;
        int          p;
        int          r;
        int          len;
        int          pair_at;
        int          idx;
        logic [7:0]  mtype;
        logic [31:0] regv [4];
        for (phase = 0; phase < 4; phase++) begin
            for (idx = 0; idx < 4; idx++) begin
                r = $urandom_range(9);
                regv[idx] = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
            end
            write_all_regs(regv[0], regv[1], regv[2], regv[3]);
            write_reg(CFG_LEASE_SECS + 3'($urandom_range(1, 4)), $urandom);
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 64; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 64; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase
            for (p = 0; p < 8; p++) begin
                r = $urandom_range(99);
                pair_at = -1;
                mtype   = MSG_DISCOVER;
                case ($urandom_range(2))
                    0: mtype = MSG_DISCOVER;
                    1: mtype = MSG_REQUEST;
                    default: mtype = 8'($urandom);
                endcase
                if (r < 70) begin
                    len = ($urandom_range(9) == 0) ? $urandom_range(321, 700)
                                                   : $urandom_range(MIN_REQUEST_BYTES, 320);
                    case ($urandom_range(4))
                        0, 1, 2: pair_at = OPTIONS_START;
                        3: pair_at = $urandom_range(OPTIONS_START - 2, len - 1);
                        default: pair_at = -1;
                    endcase
                    build_request(len, BOOTREQUEST, pair_at, mtype);
                end else if (r < 80) begin
                    len = $urandom_range(MIN_REQUEST_BYTES, 320);
                    build_request(len, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(2, 255)),
                                  OPTIONS_START, mtype);
                end else if (r < 90) begin
                    build_request($urandom_range(1, MIN_REQUEST_BYTES - 1), BOOTREQUEST,
                                  -1, 8'h00);
                end else if (r < 96) begin
                    build_request($urandom_range(1, 60), 8'($urandom), -1, 8'h00);
                end else begin
                    len = $urandom_range(PKT_MAX - 8, PKT_MAX + 72);
                    build_request(len, BOOTREQUEST, $urandom_range(OPTIONS_START, len - 3), mtype);
                end
                send_packet();
                // Pause the sender once until the reply has fully drained
                if (phase == 1 && p == 3)
                    wait_replies_drained();
            end
        end
        gap_pct   = 0;
        stall_pct = 0;
    endtask

    initial begin
        // Drive every input to a known value before the first edge
        aresetn         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = CFG_OFFERED_ADDR;
        cfg_data        = 32'h0;
        s_valid         = 1'b0;
        s_data_byte     = 8'h00;
        s_end_of_packet = 1'b0;

        cfg_offered = OFFERED_ADDR_RST;
        cfg_mask    = SUBNET_MASK_RST;
        cfg_server  = ROUTER_ADDR_RST;
        cfg_lease   = LEASE_SECS_RST;
        clear_request();

        // Hold reset, then release it on a falling edge
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_message_type_scan();
        test_rejected_requests();
        test_register_extremes();
        test_saturated_length();
        test_random_traffic();

        // Wait for the last reply, then keep clocking so that a stray beat is still caught
        wait_replies_drained();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0 && reply_words_due.size() == 0) begin
            $display("dhcp_reply_responder_top verification clean");
        end else begin
            $display("dhcp_reply_responder_top verification failed");
        end
        $finish;
    end

endmodule
